>>> design/pbe_pkg.sv
// ----------------------------------------------------------------------------
// pbe_pkg
// Shared constants, types and control encodings for the PackBits encoder.
// ----------------------------------------------------------------------------
package pbe_pkg;

  // Longest packet the encoder builds; also the depth of the pending buffer.
  localparam int MAX_PACKET = 128;
  localparam int CNT_W      = $clog2(MAX_PACKET + 2);
  localparam int ADDR_W     = $clog2(MAX_PACKET);

  localparam logic [7:0] END_MARKER = 8'd128;
  localparam logic [8:0] RUN_BASE   = 9'd257;

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TAKE,
    ST_FCHK,
    ST_HDR,
    ST_SYM,
    ST_LIT,
    ST_APPLY,
    ST_MARK,
    ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    CMD_NOP,
    CMD_LOAD,
    CMD_TAKE,
    CMD_HDR,
    CMD_SYM,
    CMD_LIT,
    CMD_APPLY,
    CMD_MARK,
    CMD_DONE
  } cmd_t;

  typedef enum logic [1:0] {
    FK_NONE,
    FK_RUN,
    FK_LIT
  } flush_kind_t;

  typedef struct packed {
    logic        emit_ok;   // a byte offered now is taken by the packer
    logic        done_ok;   // the closing word can be handed over
    logic        fin;       // transaction ends the stream
    logic        lit_end;   // last literal byte of the packet is on offer
    flush_kind_t kind;      // packet that the current flush pass emits
  } dp_status_t;

endpackage

>>> design/pbe_ctrl.sv
// ----------------------------------------------------------------------------
// pbe_ctrl
// Sequencer: steps each transaction through take, flush, apply and close.
// ----------------------------------------------------------------------------
module pbe_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pbe_pkg::dp_status_t status,
  output pbe_pkg::cmd_t      cmd
);

  pbe_pkg::state_t state_r, state_nxt;
  logic            phase_r, phase_nxt;   // 0: flush before the byte, 1: end flush
  pbe_pkg::state_t after_flush;

  assign after_flush = phase_r ? pbe_pkg::ST_MARK : pbe_pkg::ST_APPLY;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    unique case (state_r)
      pbe_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = pbe_pkg::ST_TAKE;
      end
      pbe_pkg::ST_TAKE: begin
        state_nxt = pbe_pkg::ST_FCHK;
        phase_nxt = 1'b0;
      end
      pbe_pkg::ST_FCHK: begin
        state_nxt = (status.kind == pbe_pkg::FK_NONE) ? after_flush : pbe_pkg::ST_HDR;
      end
      pbe_pkg::ST_HDR: begin
        if (status.emit_ok)
          state_nxt = (status.kind == pbe_pkg::FK_RUN) ? pbe_pkg::ST_SYM : pbe_pkg::ST_LIT;
      end
      pbe_pkg::ST_SYM: begin
        if (status.emit_ok) state_nxt = after_flush;
      end
      pbe_pkg::ST_LIT: begin
        if (status.emit_ok && status.lit_end) state_nxt = after_flush;
      end
      pbe_pkg::ST_APPLY: begin
        state_nxt = status.fin ? pbe_pkg::ST_FCHK : pbe_pkg::ST_DONE;
        phase_nxt = 1'b1;
      end
      pbe_pkg::ST_MARK: begin
        if (status.emit_ok) state_nxt = pbe_pkg::ST_DONE;
      end
      pbe_pkg::ST_DONE: begin
        if (status.done_ok) state_nxt = pbe_pkg::ST_IDLE;
      end
      default: state_nxt = pbe_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    cmd      = pbe_pkg::CMD_NOP;
    unique case (state_r)
      pbe_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) cmd = pbe_pkg::CMD_LOAD;
      end
      pbe_pkg::ST_TAKE:  cmd = pbe_pkg::CMD_TAKE;
      pbe_pkg::ST_FCHK:  cmd = pbe_pkg::CMD_NOP;
      pbe_pkg::ST_HDR:   cmd = pbe_pkg::CMD_HDR;
      pbe_pkg::ST_SYM:   cmd = pbe_pkg::CMD_SYM;
      pbe_pkg::ST_LIT:   cmd = pbe_pkg::CMD_LIT;
      pbe_pkg::ST_APPLY: cmd = pbe_pkg::CMD_APPLY;
      pbe_pkg::ST_MARK:  cmd = pbe_pkg::CMD_MARK;
      pbe_pkg::ST_DONE:  cmd = pbe_pkg::CMD_DONE;
      default:           cmd = pbe_pkg::CMD_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pbe_pkg::ST_IDLE;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

>>> design/pbe_datapath.sv
// ----------------------------------------------------------------------------
// pbe_datapath
// Pending buffer, run/literal state, byte emitter, word packer, output stage.
// ----------------------------------------------------------------------------
module pbe_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  pbe_pkg::cmd_t       cmd,
  output pbe_pkg::dp_status_t status,
  input  logic [7:0]          in_data_byte,
  input  logic                in_byte_valid,
  input  logic                in_final_item,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [63:0]         out_word,
  output logic [3:0]          out_count,
  output logic                out_last_word
);

  logic [7:0] mem [pbe_pkg::MAX_PACKET];

  // latched transaction
  logic [7:0] v_r, v_nxt;
  logic       bv_r, bv_nxt;
  logic       fin_r, fin_nxt;

  // encoder state
  logic          mode_r, mode_nxt;     // 1 run, 0 literal
  pbe_pkg::cnt_t cnt_r, cnt_nxt;
  logic [7:0]    last_r, last_nxt;
  logic [7:0]    prev_r, prev_nxt;

  // flush pass parameters and deferred buffer write
  pbe_pkg::flush_kind_t fl_kind_r, fl_kind_nxt;
  pbe_pkg::cnt_t        fl_len_r, fl_len_nxt;
  logic [7:0]           fl_sym_r, fl_sym_nxt;
  logic                 wr_pend_r, wr_pend_nxt;
  pbe_pkg::addr_t       wr_addr_r, wr_addr_nxt;
  pbe_pkg::cnt_t        rd_idx_r, rd_idx_nxt;
  logic [7:0]           rdata_r;

  // packer and output stage
  logic [63:0] pk_word_r, pk_word_nxt;
  logic [3:0]  pk_cnt_r, pk_cnt_nxt;
  logic        ov_r, ov_nxt;
  logic [63:0] ow_r, ow_nxt;
  logic [3:0]  oc_r, oc_nxt;
  logic        ol_r, ol_nxt;

  logic           out_free, pk_full, emit_req, emit_ok, advance;
  logic           mem_we, rd_en;
  pbe_pkg::addr_t rd_addr;
  logic [7:0]     emit_byte, run_hdr, lit_hdr;
  logic           eq, triple;

  assign out_free = !ov_r || !out_stall;
  assign pk_full  = (pk_cnt_r == 4'd8);
  assign emit_ok  = !pk_full || out_free;
  assign run_hdr  = 8'(pbe_pkg::RUN_BASE - 9'(fl_len_r));
  assign lit_hdr  = 8'(fl_len_r - pbe_pkg::cnt_t'(1));
  assign eq       = (v_r == last_r);
  assign triple   = eq && (prev_r == last_r);

  assign status.emit_ok = emit_ok;
  assign status.done_ok = (pk_cnt_r == 4'd0) || out_free;
  assign status.fin     = fin_r;
  assign status.lit_end = (rd_idx_r == fl_len_r - pbe_pkg::cnt_t'(1));
  assign status.kind    = fl_kind_r;

  always_comb begin
    emit_req  = 1'b0;
    emit_byte = 8'd0;
    unique case (cmd)
      pbe_pkg::CMD_HDR: begin
        emit_req  = 1'b1;
        emit_byte = (fl_kind_r == pbe_pkg::FK_RUN) ? run_hdr : lit_hdr;
      end
      pbe_pkg::CMD_SYM: begin
        emit_req  = 1'b1;
        emit_byte = fl_sym_r;
      end
      pbe_pkg::CMD_LIT: begin
        emit_req  = 1'b1;
        emit_byte = rdata_r;
      end
      pbe_pkg::CMD_MARK: begin
        emit_req  = 1'b1;
        emit_byte = pbe_pkg::END_MARKER;
      end
      default: begin
        emit_req  = 1'b0;
        emit_byte = 8'd0;
      end
    endcase
  end

  assign advance = emit_req && emit_ok;

  always_comb begin
    v_nxt       = v_r;
    bv_nxt      = bv_r;
    fin_nxt     = fin_r;
    mode_nxt    = mode_r;
    cnt_nxt     = cnt_r;
    last_nxt    = last_r;
    prev_nxt    = prev_r;
    fl_kind_nxt = fl_kind_r;
    fl_len_nxt  = fl_len_r;
    fl_sym_nxt  = fl_sym_r;
    wr_pend_nxt = wr_pend_r;
    wr_addr_nxt = wr_addr_r;
    rd_idx_nxt  = rd_idx_r;
    mem_we      = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = '0;

    unique case (cmd)
      pbe_pkg::CMD_LOAD: begin
        v_nxt   = in_data_byte;
        bv_nxt  = in_byte_valid;
        fin_nxt = in_final_item;
      end
      pbe_pkg::CMD_TAKE: begin
        fl_kind_nxt = pbe_pkg::FK_NONE;
        fl_len_nxt  = cnt_r;
        fl_sym_nxt  = last_r;
        wr_pend_nxt = 1'b0;
        if (bv_r) begin
          // default outcome: byte appended at the end of the buffer
          cnt_nxt     = cnt_r + pbe_pkg::cnt_t'(1);
          prev_nxt    = last_r;
          last_nxt    = v_r;
          wr_pend_nxt = !mode_r || (cnt_r <= pbe_pkg::cnt_t'(1));
          wr_addr_nxt = pbe_pkg::addr_t'(cnt_r);
          if (cnt_r == '0) begin
            wr_addr_nxt = '0;
          end else if (mode_r) begin
            if (!eq && cnt_r == pbe_pkg::cnt_t'(1)) begin
              mode_nxt = 1'b0;
            end else if (!eq || cnt_r >= pbe_pkg::cnt_t'(pbe_pkg::MAX_PACKET)) begin
              fl_kind_nxt = pbe_pkg::FK_RUN;
              cnt_nxt     = pbe_pkg::cnt_t'(1);
              wr_pend_nxt = 1'b1;
              wr_addr_nxt = '0;
            end
          end else if (cnt_r > pbe_pkg::cnt_t'(1)) begin
            if (triple) begin
              // two equal bytes leave the literal and open a run of three
              if (cnt_r > pbe_pkg::cnt_t'(2)) fl_kind_nxt = pbe_pkg::FK_LIT;
              fl_len_nxt  = cnt_r - pbe_pkg::cnt_t'(2);
              mode_nxt    = 1'b1;
              cnt_nxt     = pbe_pkg::cnt_t'(3);
              wr_pend_nxt = 1'b0;
            end else if (cnt_r >= pbe_pkg::cnt_t'(pbe_pkg::MAX_PACKET)) begin
              fl_kind_nxt = pbe_pkg::FK_LIT;
              cnt_nxt     = pbe_pkg::cnt_t'(1);
              wr_addr_nxt = '0;
            end
          end
        end
      end
      pbe_pkg::CMD_HDR: begin
        rd_addr = '0;
        rd_en   = advance;
        if (advance) rd_idx_nxt = '0;
      end
      pbe_pkg::CMD_LIT: begin
        rd_addr = pbe_pkg::addr_t'(rd_idx_r + pbe_pkg::cnt_t'(1));
        rd_en   = advance;
        if (advance) rd_idx_nxt = rd_idx_r + pbe_pkg::cnt_t'(1);
      end
      pbe_pkg::CMD_APPLY: begin
        mem_we      = wr_pend_r;
        wr_pend_nxt = 1'b0;
        if (fin_r) begin
          if (cnt_r == '0)  fl_kind_nxt = pbe_pkg::FK_NONE;
          else if (mode_r)  fl_kind_nxt = pbe_pkg::FK_RUN;
          else              fl_kind_nxt = pbe_pkg::FK_LIT;
          fl_len_nxt = cnt_r;
          fl_sym_nxt = last_r;
          mode_nxt   = 1'b1;
          cnt_nxt    = '0;
        end
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // packer: a full word leaves only when the next byte arrives or the item closes
  always_comb begin
    pk_word_nxt = pk_word_r;
    pk_cnt_nxt  = pk_cnt_r;
    ov_nxt      = ov_r && out_stall;
    ow_nxt      = ow_r;
    oc_nxt      = oc_r;
    ol_nxt      = ol_r;
    if (advance) begin
      if (pk_full) begin
        ov_nxt      = 1'b1;
        ow_nxt      = pk_word_r;
        oc_nxt      = 4'd8;
        ol_nxt      = 1'b0;
        pk_word_nxt = 64'(emit_byte);
        pk_cnt_nxt  = 4'd1;
      end else begin
        if (pk_cnt_r == 4'd0) pk_word_nxt = 64'(emit_byte);
        else pk_word_nxt[{pk_cnt_r[2:0], 3'b000} +: 8] = emit_byte;
        pk_cnt_nxt = pk_cnt_r + 4'd1;
      end
    end else if (cmd == pbe_pkg::CMD_DONE && pk_cnt_r != 4'd0 && out_free) begin
      ov_nxt     = 1'b1;
      ow_nxt     = pk_word_r;
      oc_nxt     = pk_cnt_r;
      ol_nxt     = 1'b1;
      pk_cnt_nxt = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr_r] <= v_r;
    if (rd_en)  rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= 1'b1;
      cnt_r     <= '0;
      fl_kind_r <= pbe_pkg::FK_NONE;
      wr_pend_r <= 1'b0;
      pk_cnt_r  <= 4'd0;
      ov_r      <= 1'b0;
    end else begin
      mode_r    <= mode_nxt;
      cnt_r     <= cnt_nxt;
      fl_kind_r <= fl_kind_nxt;
      wr_pend_r <= wr_pend_nxt;
      pk_cnt_r  <= pk_cnt_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r       <= v_nxt;
    bv_r      <= bv_nxt;
    fin_r     <= fin_nxt;
    last_r    <= last_nxt;
    prev_r    <= prev_nxt;
    fl_len_r  <= fl_len_nxt;
    fl_sym_r  <= fl_sym_nxt;
    wr_addr_r <= wr_addr_nxt;
    rd_idx_r  <= rd_idx_nxt;
    pk_word_r <= pk_word_nxt;
    ow_r      <= ow_nxt;
    oc_r      <= oc_nxt;
    ol_r      <= ol_nxt;
  end

  assign out_valid     = ov_r;
  assign out_word      = ow_r;
  assign out_count     = oc_r;
  assign out_last_word = ol_r;

endmodule

>>> design/packbits_encoder_core.sv
// ----------------------------------------------------------------------------
// packbits_encoder_core
// PackBits run-length encoder, one raw byte per transaction in, packed
// 64-bit words of encoded stream out.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall with in_data_byte, in_byte_valid and
//   in_final_item. A transaction with in_byte_valid low carries no byte; one
//   with in_final_item high flushes the pending packet and appends the end
//   marker 128, after taking its own byte.
// Output channel: out_valid/out_stall with out_word (first byte in bits 7:0,
//   unused lanes zero), out_count (1..8) and out_last_word, set on the last
//   word a transaction produces. A transaction that emits no byte gives no
//   word. All words but the last of a transaction carry 8 bytes.
// Throughput: one transaction at a time, emitting up to 132 encoded bytes;
//   the byte emitter feeding the word packer moves one byte per cycle while
//   the packer can take it, literal bytes coming from the pending buffer's
//   registered port.
// Stall: a held output word pauses the emitter once the packer is full;
//   nothing is dropped, in_stall stays high until the transaction closes.
// Reset (rst_n low, synchronous): run mode, empty buffer, no output pending.
//   The buffer memory itself is not cleared; only written entries are read.
// ----------------------------------------------------------------------------
module packbits_encoder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_valid,
  input  logic        in_final_item,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_word,
  output logic [3:0]  out_count,
  output logic        out_last_word
);

  pbe_pkg::cmd_t       cmd;      // sequencer step for the datapath
  pbe_pkg::dp_status_t status;   // handshake and flush info back to sequencer

  // Sequencer: walks take -> first flush -> buffer update -> end flush/marker
  // -> close word, holding in_stall high for the whole transaction.
  pbe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: pending buffer memory, run/literal state, packer, output stage.
  pbe_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .in_data_byte  (in_data_byte),
    .in_byte_valid (in_byte_valid),
    .in_final_item (in_final_item),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_word      (out_word),
    .out_count     (out_count),
    .out_last_word (out_last_word)
  );

  // An accepted transaction blocks the input until it closes.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again right after a transaction");

  // Only the closing word of a transaction may be partly filled.
  a_full_unless_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_word) |-> (out_count == 4'd8))
    else $error("partial word not flagged as last");

  // Byte count is in range and lanes above it are zero.
  a_lanes_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_count != 4'd0 && out_count <= 4'd8 &&
                   (out_word >> {out_count, 3'b000}) == 64'd0))
    else $error("bad byte count or dirty lanes in output word");

  // A new transaction is taken only in the load step, with the packer empty or able to hand its word over.
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> (cmd == pbe_pkg::CMD_LOAD && status.done_ok))
    else $error("transaction accepted with unsent bytes");

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for packbits_encoder_core. Raw byte transactions go in
// through the valid/stall channel. A PackBits model in the bench predicts the
// packed output words. Each accepted word is checked field by field against
// the oldest prediction. Sender gaps and receiver stalls change from phase
// to phase.
// ----------------------------------------------------------------------------

// One predicted output word.
typedef struct {
  logic [63:0] word;
  logic [3:0]  count;
  logic        last;
} enc_word_t;

// Kind of long segment forced at the start of a phase.
typedef enum int {
  LONG_NONE,
  LONG_LITERAL
} long_seg_t;

class packbits_scoreboard;
  logic        run_mode;
  logic [7:0]  pend_buf [pbe_pkg::MAX_PACKET + 1];
  int          pend_cnt;
  logic [7:0]  packet_bytes [$];
  enc_word_t   expected_words [$];
  int          fail_cnt;

  function new();
    fail_cnt = 0;
    restart();
  endfunction

  function void restart();
    run_mode = 1'b1;
    pend_cnt = 0;
  endfunction

  function void put_byte(logic [7:0] b);
    packet_bytes.insert(packet_bytes.size(), b);
  endfunction

  function void emit_run();
    if (pend_cnt == 0) return;
    put_byte(8'(pbe_pkg::RUN_BASE - pend_cnt));
    put_byte(pend_buf[pend_cnt - 1]);
    pend_cnt = 0;
  endfunction

  function void emit_literal();
    if (pend_cnt == 0) return;
    put_byte(8'(pend_cnt - 1));
    for (int i = 0; i < pend_cnt; i++) put_byte(pend_buf[i]);
    pend_cnt = 0;
  endfunction

  function void absorb_byte(logic [7:0] v);
    int         n;
    logic [7:0] tail_b;
    logic [7:0] prev_b;
    n = pend_cnt;
    if (n != 0) begin
      tail_b = pend_buf[n - 1];
      if (run_mode) begin
        if (tail_b != v) begin
          if (n > 1) emit_run();
          else run_mode = 1'b0;
        end else if (n >= pbe_pkg::MAX_PACKET) begin
          emit_run();
        end
      end else if (n > 1) begin
        prev_b = pend_buf[n - 2];
        if (prev_b == tail_b && v == tail_b) begin
          // Two equal bytes plus this one: cut them off the literal into a run.
          pend_cnt = n - 2;
          emit_literal();
          pend_buf[0] = prev_b;
          pend_buf[1] = tail_b;
          pend_cnt = 2;
          run_mode = 1'b1;
        end else if (n >= pbe_pkg::MAX_PACKET) begin
          emit_literal();
        end
      end
    end
    if (pend_cnt < pbe_pkg::MAX_PACKET + 1) begin
      pend_buf[pend_cnt] = v;
      pend_cnt++;
    end
  endfunction

  // Called on every accepted input transaction.
  function void encode_item(logic [7:0] data, logic bv, logic fin);
    int        nwords;
    int        cnt;
    enc_word_t w;
    packet_bytes.delete();
    if (bv) absorb_byte(data);
    if (fin) begin
      if (run_mode) emit_run();
      else emit_literal();
      put_byte(pbe_pkg::END_MARKER);
      restart();
    end
    nwords = (packet_bytes.size() + 7) / 8;
    for (int k = 0; k < nwords; k++) begin
      cnt = packet_bytes.size() - k * 8;
      if (cnt > 8) cnt = 8;
      w.word  = '0;
      for (int j = 0; j < cnt; j++) w.word |= 64'(packet_bytes[k * 8 + j]) << (8 * j);
      w.count = 4'(cnt);
      w.last  = (k + 1 == nwords);
      expected_words.insert(expected_words.size(), w);
    end
  endfunction

  // Called on every accepted output transaction.
  function void check_word(logic [63:0] word, logic [3:0] count, logic last);
    enc_word_t e;
    if (expected_words.size() == 0) begin
      $error("unexpected output word %h (count %0d, last %b)", word, count, last);
      fail_cnt++;
      return;
    end
    e = expected_words.pop_front();
    if (word !== e.word) begin
      $error("out_word: expected %h, got %h", e.word, word);
      fail_cnt++;
    end
    if (count !== e.count) begin
      $error("out_count: expected %0d, got %0d", e.count, count);
      fail_cnt++;
    end
    if (last !== e.last) begin
      $error("out_last_word: expected %b, got %b", e.last, last);
      fail_cnt++;
    end
  endfunction

  function int outstanding();
    return expected_words.size();
  endfunction
endclass

module tb_top;

  // Worst case is far below this: ~210 transactions, each with at most
  // 17 words under heavy stall plus flush work for up to 132 bytes.
  localparam int CYCLE_LIMIT  = 2000000;
  // Idle time before the final check; one transaction emits at most 132 bytes.
  localparam int DRAIN_CYCLES = 150;
  localparam int PHASE_ITEMS  = 8;

  logic        clk;
  logic        rst_n         = 1'b0;
  logic        in_valid      = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte  = 8'h00;
  logic        in_byte_valid = 1'b0;
  logic        in_final_item = 1'b0;
  logic        out_valid;
  logic        out_stall     = 1'b0;
  logic [63:0] out_word;
  logic [3:0]  out_count;
  logic        out_last_word;

  packbits_scoreboard sb = new();

  int          cycles = 0;
  int          sender_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          items_sent = 0;    // transactions that carry a byte or end the stream
  logic [7:0]  last_sent = 8'h00;

  packbits_encoder_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_byte  (in_data_byte),
    .in_byte_valid (in_byte_valid),
    .in_final_item (in_final_item),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_word      (out_word),
    .out_count     (out_count),
    .out_last_word (out_last_word)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Global watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: random back-pressure at the current phase's rate.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Output monitor. Values read here are the pre-edge ones, so the
  // check does not race the DUT's own updates at this edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_word(out_word, out_count, out_last_word);
    end
  end

  // One input transaction: optional random gap, then hold until accepted.
  // Always entered and left right after a rising edge.
  task automatic send_item(input logic [7:0] d, input logic bv, input logic fin);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid     <= 1'b0;
      in_data_byte <= 8'($urandom);
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data_byte  <= d;
    in_byte_valid <= bv;
    in_final_item <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.encode_item(d, bv, fin);
    if (bv) last_sent = d;
    if (bv || fin) items_sent++;
  endtask

  task automatic send_run(input logic [7:0] v, input int len);
    for (int i = 0; i < len; i++) send_item(v, 1'b1, 1'b0);
  endtask

  // Adjacent bytes always differ, so no triple can form inside.
  task automatic send_literal(input int len);
    logic [7:0] v;
    for (int i = 0; i < len; i++) begin
      do v = 8'($urandom); while (v == last_sent);
      send_item(v, 1'b1, 1'b0);
    end
  endtask

  // Sender holds off until every predicted word has been taken.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  // One traffic phase: optional long segment, then random stream content
  // built from runs, literals and near-triples, closed by an end of stream.
  task automatic run_phase(input int idle_pct, input int stall_pct, input long_seg_t long_kind);
    int         start_cnt;
    int         r;
    logic [7:0] alpha [3];
    logic [7:0] v;
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    start_cnt = items_sent;
    for (int i = 0; i < 3; i++) alpha[i] = 8'($urandom);
    case (long_kind)
      LONG_LITERAL: begin
        // Full literal is flushed by the next byte; then a triple is cut
        // from the two-byte literal that follows, leaving nothing to emit.
        send_literal(pbe_pkg::MAX_PACKET);
        do v = 8'($urandom); while (v == last_sent);
        send_run(v, 3);
        send_literal($urandom_range(1, 4));
        send_item(8'($urandom), 1'b0, 1'b1);
      end
      default: ;
    endcase
    start_cnt = items_sent;
    while (items_sent - start_cnt < PHASE_ITEMS) begin
      r = $urandom_range(99);
      if (r < 30) begin
        send_run(8'($urandom), $urandom_range(1, 5));
      end else if (r < 55) begin
        send_literal($urandom_range(1, 8));
      end else if (r < 75) begin
        // Small alphabet: pairs and triples in random places.
        for (int i = $urandom_range(1, 6); i > 0; i--) begin
          send_item(alpha[$urandom_range(2)], 1'b1, 1'b0);
        end
      end else if (r < 85) begin
        send_item(8'($urandom), 1'b0, 1'b0);
      end else begin
        send_item(8'($urandom), 1'($urandom_range(1)), 1'b1);
      end
    end
    send_item(8'($urandom), 1'($urandom_range(1)), 1'b1);
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, no idling.
    send_item(8'($urandom), 1'b0, 1'b1);          // end marker on an empty buffer
    send_item(8'($urandom), 1'b0, 1'b0);          // flush-only, no output
    send_item(8'h00, 1'b1, 1'b1);                 // byte taken, then end of stream
    send_run(8'hFF, 3);
    send_item(8'($urandom), 1'b0, 1'b1);
    send_item(8'h01, 1'b1, 1'b0);
    send_item(8'h02, 1'b1, 1'b0);
    send_item(8'h03, 1'b1, 1'b1);                 // literal closed by the final byte
    send_item(8'h10, 1'b1, 1'b0);
    send_run(8'h20, 3);                           // triple cut from a literal
    send_item(8'($urandom), 1'b0, 1'b1);
    send_run(8'h55, 2);
    send_item(8'hAA, 1'b1, 1'b0);                 // run broken by a new byte
    send_item(8'hAA, 1'b1, 1'b1);
    send_item(8'h7F, 1'b1, 1'b0);
    send_run(8'h80, 2);                           // pair inside a literal
    send_item(8'h81, 1'b1, 1'b1);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'($urandom), 1'b0, 1'b0);          // flush-only mid stream
    send_item(8'h80, 1'b1, 1'b1);
    wait_drained();

    run_phase(0,  0,  LONG_NONE);
    run_phase(82, 0,  LONG_NONE);
    run_phase(0,  82, LONG_LITERAL);
    run_phase(8,  8,  LONG_NONE);

    recv_stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.fail_cnt == 0 && sb.outstanding() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
design/pbe_pkg.sv
design/pbe_ctrl.sv
design/pbe_datapath.sv
design/packbits_encoder_core.sv
tb/sv/tb_top.sv
